### rtl/lci_pkg.sv
// package: widths and constants for the line/circle clip
package lci_pkg;

  localparam int COORD_BITS_DEF     = 15;
  localparam int ROOT_FRAC_BITS_DEF = 8;
  localparam int HALF_WIDTH_BITS    = 8;
  localparam int RADIUS_BITS        = 10;
  localparam int OUT_BITS           = 16;
  localparam logic [HALF_WIDTH_BITS-1:0] HALF_WIDTH_RESET = 8'd3;

endpackage

### rtl/lci_sqrt_cell.sv
// one digit of a pipelined restoring square root, with sideband pass-through
module lci_sqrt_cell
  import lci_pkg::*;
#(
  parameter int RW = 48,
  parameter int VW = 96,
  parameter int SW = 8,
  parameter int STEP = 0
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          vin,
  input  logic [VW-1:0] val_in,
  input  logic [RW+1:0] rem_in,
  input  logic [RW-1:0] root_in,
  input  logic [SW-1:0] side_in,
  output logic          vout,
  output logic [VW-1:0] val_out,
  output logic [RW+1:0] rem_out,
  output logic [RW-1:0] root_out,
  output logic [SW-1:0] side_out
);

  localparam int PAIR = VW - 2 - 2 * STEP;

  logic [RW+1:0] rem_sh;
  logic [RW+1:0] trial;
  logic [RW-1:0] root_sh;

  always_comb begin
    rem_sh  = {rem_in[RW-1:0], val_in[PAIR+1 -: 2]};
    root_sh = {root_in[RW-2:0], 1'b0};
    trial   = {root_in, 2'b01};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vout <= 1'b0;
    end else if (en) begin
      vout <= vin;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      val_out  <= val_in;
      side_out <= side_in;
      if (rem_sh >= trial) begin
        rem_out  <= rem_sh - trial;
        root_out <= root_sh | {{(RW-1){1'b0}}, 1'b1};
      end else begin
        rem_out  <= rem_sh;
        root_out <= root_sh;
      end
    end
  end

endmodule

### rtl/lci_div_cell.sv
// one quotient bit of a pipelined restoring divider on magnitudes
module lci_div_cell
  import lci_pkg::*;
#(
  parameter int NW = 80,
  parameter int DW = 40,
  parameter int SW = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          vin,
  input  logic [NW-1:0] num_in,
  input  logic [DW:0]   rem_in,
  input  logic [DW-1:0] den_in,
  input  logic [SW-1:0] side_in,
  output logic          vout,
  output logic [NW-1:0] num_out,
  output logic [DW:0]   rem_out,
  output logic [DW-1:0] den_out,
  output logic [SW-1:0] side_out
);

  logic [DW+1:0] rem_sh;
  logic [DW+1:0] diff;

  always_comb begin
    rem_sh = {rem_in, num_in[NW-1]};
    diff   = rem_sh - {2'b00, den_in};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vout <= 1'b0;
    end else if (en) begin
      vout <= vin;
    end
  end

  // quotient bits shift into the low end of num as the numerator drains out
  always_ff @(posedge clk) begin
    if (en) begin
      den_out  <= den_in;
      side_out <= side_in;
      if (!diff[DW+1]) begin
        rem_out <= diff[DW:0];
        num_out <= {num_in[NW-2:0], 1'b1};
      end else begin
        rem_out <= rem_sh[DW:0];
        num_out <= {num_in[NW-2:0], 1'b0};
      end
    end
  end

endmodule

### rtl/line_circle_intersection_clip.sv
// top level: line/circle clip as a chain of root and divider cells
//
// channel  | signals                                         | handshake
// in       | in_valid, in_stall, start/end/center, radius   | valid & !stall
// out      | out_valid, out_stall, new_end_x/y, valid_res    | valid & !stall
// cfg      | cfg_valid, cfg_ready, cfg_data                  | valid & ready
//
// one item enters per cycle while the chain advances; the pipeline is 5
// front stages, 37 root cells, 2 stages, 63 divider cells (four dividers
// side by side) and 2 back stages. the whole chain advances together; it
// holds when the output register is full and stalled. rst is synchronous
// and clears valid bits and the half-width register to 3; in_stall is high
// and cfg_ready low during rst. no clearing pass.
module line_circle_intersection_clip
  import lci_pkg::*;
#(
  parameter int COORD_BITS     = COORD_BITS_DEF,
  parameter int ROOT_FRAC_BITS = ROOT_FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [COORD_BITS-1:0]  start_x,
  input  logic signed [COORD_BITS-1:0]  start_y,
  input  logic signed [COORD_BITS-1:0]  end_x,
  input  logic signed [COORD_BITS-1:0]  end_y,
  input  logic signed [COORD_BITS-1:0]  center_x,
  input  logic signed [COORD_BITS-1:0]  center_y,
  input  logic [RADIUS_BITS-1:0]        obstacle_radius,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [OUT_BITS-1:0]    new_end_x,
  output logic signed [OUT_BITS-1:0]    new_end_y,
  output logic                          valid_res,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [HALF_WIDTH_BITS-1:0]    cfg_data
);

  localparam int CB  = COORD_BITS;
  localparam int DB  = CB + 2;              // delta / offset width
  localparam int DRW = 2 * DB + 1;          // dr width (unsigned)
  localparam int DTW = 2 * DB + 2;          // det width (signed)
  localparam int ADW = 2 * CB + 1;          // |det| width
  localparam int RB  = RADIUS_BITS + 1;
  localparam int RRW = 2 * RB + DRW;        // r^2*dr width
  localparam int VW  = 2 * (((RRW + 2 * ROOT_FRAC_BITS) + 1) / 2);
  localparam int RW  = VW / 2;              // root width
  localparam int NC  = RW;                  // root cells
  localparam int DENW = DRW + ROOT_FRAC_BITS;
  localparam int NW  = DTW + DB + ROOT_FRAC_BITS + 2;  // numerator magnitude
  localparam int QW  = NW;
  localparam int SW  = 1 + 6 * CB + 2 * DB + DTW + DRW;
  localparam int DSW = 1 + 4 * CB + CB + 1; // pass + start/end + centre + sign

  logic adv;
  logic [HALF_WIDTH_BITS-1:0] half_width;

  assign cfg_ready = !rst;
  always_ff @(posedge clk) begin
    if (rst) begin
      half_width <= HALF_WIDTH_RESET;
    end else if (cfg_valid) begin
      half_width <= cfg_data;
    end
  end

  // ---------------- front stages ----------------
  logic v1, v2, v3, v4;
  logic signed [CB-1:0] s1x, s1y, e1x, e1y, c1x, c1y;
  logic [RB-1:0] r1;
  logic signed [DB-1:0] dx1, dy1, ax1, ay1, bx1, by1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0; v4 <= 1'b0;
    end else if (adv) begin
      v1 <= in_valid; v2 <= v1; v3 <= v2; v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1x <= start_x; s1y <= start_y; e1x <= end_x; e1y <= end_y;
      c1x <= center_x; c1y <= center_y;
      r1  <= RB'(obstacle_radius) + RB'(half_width);
      dx1 <= DB'(end_x) - DB'(start_x);
      dy1 <= DB'(end_y) - DB'(start_y);
      ax1 <= DB'(start_x) - DB'(center_x);
      ay1 <= DB'(start_y) - DB'(center_y);
      bx1 <= DB'(end_x) - DB'(center_x);
      by1 <= DB'(end_y) - DB'(center_y);
    end
  end

  // stage 2: products
  logic signed [CB-1:0] s2x, s2y, e2x, e2y, c2x, c2y;
  logic signed [DB-1:0] dx2, dy2;
  logic [2*RB-1:0] r2sq;
  logic [DRW-1:0] dxx2, dyy2;
  logic signed [DTW-1:0] p2a, p2b;

  always_ff @(posedge clk) begin
    if (adv) begin
      s2x <= s1x; s2y <= s1y; e2x <= e1x; e2y <= e1y; c2x <= c1x; c2y <= c1y;
      dx2 <= dx1; dy2 <= dy1;
      r2sq <= (2*RB)'(r1 * r1);
      dxx2 <= DRW'(dx1) * DRW'(dx1);
      dyy2 <= DRW'(dy1) * DRW'(dy1);
      p2a  <= DTW'(ax1) * DTW'(by1);
      p2b  <= DTW'(ay1) * DTW'(bx1);
    end
  end

  // stage 3: dr and det
  logic signed [CB-1:0] s3x, s3y, e3x, e3y, c3x, c3y;
  logic signed [DB-1:0] dx3, dy3;
  logic [2*RB-1:0] r3sq;
  logic [DRW-1:0] dr3;
  logic signed [DTW-1:0] det3;
  logic [ADW-1:0] adet3;

  always_comb adet3 = det3[DTW-1] ? ADW'(-det3) : ADW'(det3);

  always_ff @(posedge clk) begin
    if (adv) begin
      s3x <= s2x; s3y <= s2y; e3x <= e2x; e3y <= e2y; c3x <= c2x; c3y <= c2y;
      dx3 <= dx2; dy3 <= dy2; r3sq <= r2sq;
      dr3  <= dxx2 + dyy2;
      det3 <= p2a - p2b;
    end
  end

  // stage 4: r^2*dr and det^2
  logic signed [CB-1:0] s4x, s4y, e4x, e4y, c4x, c4y;
  logic signed [DB-1:0] dx4, dy4;
  logic [DRW-1:0] dr4;
  logic signed [DTW-1:0] det4;
  logic [RRW-1:0] rr4;
  logic [2*ADW-1:0] d24;

  always_ff @(posedge clk) begin
    if (adv) begin
      s4x <= s3x; s4y <= s3y; e4x <= e3x; e4y <= e3y; c4x <= c3x; c4y <= c3y;
      dx4 <= dx3; dy4 <= dy3; dr4 <= dr3; det4 <= det3;
      rr4 <= RRW'(r3sq) * RRW'(dr3);
      d24 <= (2*ADW)'(adet3) * (2*ADW)'(adet3);
    end
  end

  // stage 5: discriminant and pass decision
  logic v5;
  logic [VW-1:0] val5;
  logic [SW-1:0] side5;
  logic pass4;
  always_comb pass4 = (dr4 == '0) || (d24 > rr4);

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (adv) begin
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      val5  <= pass4 ? '0 : (VW'(rr4 - d24) << (2 * ROOT_FRAC_BITS));
      side5 <= {pass4, s4x, s4y, e4x, e4y, c4x, c4y, dx4, dy4, det4, dr4};
    end
  end

  // ---------------- root chain ----------------
  logic          rv   [0:NC];
  logic [VW-1:0] rval [0:NC];
  logic [RW+1:0] rrem [0:NC];
  logic [RW-1:0] rroot[0:NC];
  logic [SW-1:0] rside[0:NC];

  assign rv[0] = v5;
  assign rval[0] = val5;
  assign rrem[0] = '0;
  assign rroot[0] = '0;
  assign rside[0] = side5;

  for (genvar g = 0; g < NC; g++) begin : g_root
    lci_sqrt_cell #(.RW(RW), .VW(VW), .SW(SW), .STEP(g)) u_cell (
      .clk(clk), .rst(rst), .en(adv),
      .vin(rv[g]), .val_in(rval[g]), .rem_in(rrem[g]), .root_in(rroot[g]),
      .side_in(rside[g]),
      .vout(rv[g+1]), .val_out(rval[g+1]), .rem_out(rrem[g+1]),
      .root_out(rroot[g+1]), .side_out(rside[g+1])
    );
  end

  logic signed [CB-1:0] sqx, sqy, eqx, eqy, cqx, cqy;
  logic signed [DB-1:0] dxq, dyq;
  logic signed [DTW-1:0] detq;
  logic [DRW-1:0] drq;
  logic passq;
  assign {passq, sqx, sqy, eqx, eqy, cqx, cqy, dxq, dyq, detq, drq} = rside[NC];

  // stage A: products for numerators
  localparam int PRW = DTW + DB + ROOT_FRAC_BITS + 1;
  logic va, vb;
  logic passa;
  logic signed [CB-1:0] sax, say, eax, eay, cax, cay;
  logic [DRW-1:0] dra;
  logic signed [PRW-1:0] bxa, bya, txa, tya;
  logic signed [DB:0] sdx;
  logic [DB-1:0] ady;

  always_comb begin
    sdx = dyq[DB-1] ? -(DB+1)'(dxq) : (DB+1)'(dxq);
    ady = dyq[DB-1] ? DB'(-dyq) : DB'(dyq);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0; vb <= 1'b0;
    end else if (adv) begin
      va <= rv[NC]; vb <= va;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      passa <= passq;
      sax <= sqx; say <= sqy; eax <= eqx; eay <= eqy; cax <= cqx; cay <= cqy;
      dra <= drq;
      bxa <= (PRW'(detq) * PRW'(dyq)) <<< ROOT_FRAC_BITS;
      bya <= -((PRW'(detq) * PRW'(dxq)) <<< ROOT_FRAC_BITS);
      txa <= PRW'(sdx) * PRW'($signed({1'b0, rroot[NC]}));
      tya <= PRW'($signed({1'b0, ady})) * PRW'($signed({1'b0, rroot[NC]}));
    end
  end

  // stage B: four numerators as sign + magnitude
  logic passb;
  logic signed [CB-1:0] sbx, sby, ebx, eby, cbx, cby;
  logic [DENW-1:0] denb;
  logic [3:0] sgnb;
  logic [NW-1:0] magb [0:3];
  logic signed [NW:0] nsum [0:3];

  always_comb begin
    nsum[0] = (NW+1)'(bxa) + (NW+1)'(txa);
    nsum[1] = (NW+1)'(bya) + (NW+1)'(tya);
    nsum[2] = (NW+1)'(bxa) - (NW+1)'(txa);
    nsum[3] = (NW+1)'(bya) - (NW+1)'(tya);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      passb <= passa;
      sbx <= sax; sby <= say; ebx <= eax; eby <= eay; cbx <= cax; cby <= cay;
      denb <= DENW'(dra) << ROOT_FRAC_BITS;
      for (int k = 0; k < 4; k++) begin
        sgnb[k] <= nsum[k][NW];
        magb[k] <= nsum[k][NW] ? NW'(-nsum[k]) : NW'(nsum[k]);
      end
    end
  end

  // ---------------- divider chains ----------------
  logic              qv   [0:3][0:QW];
  logic [NW-1:0]     qnum [0:3][0:QW];
  logic [DENW:0]     qrem [0:3][0:QW];
  logic [DENW-1:0]   qden [0:3][0:QW];
  logic [DSW-1:0]    qside[0:3][0:QW];

  for (genvar k = 0; k < 4; k++) begin : g_div
    assign qv[k][0]   = vb;
    assign qnum[k][0] = magb[k];
    assign qrem[k][0] = '0;
    assign qden[k][0] = denb;
    assign qside[k][0] = {passb, sbx, sby, ebx, eby,
                          (k == 0 || k == 2) ? cbx : cby, sgnb[k]};
    for (genvar g = 0; g < QW; g++) begin : g_cell
      lci_div_cell #(.NW(NW), .DW(DENW), .SW(DSW)) u_cell (
        .clk(clk), .rst(rst), .en(adv),
        .vin(qv[k][g]), .num_in(qnum[k][g]), .rem_in(qrem[k][g]),
        .den_in(qden[k][g]), .side_in(qside[k][g]),
        .vout(qv[k][g+1]), .num_out(qnum[k][g+1]), .rem_out(qrem[k][g+1]),
        .den_out(qden[k][g+1]), .side_out(qside[k][g+1])
      );
    end
  end

  // ---------------- back stages ----------------
  logic passz;
  logic signed [CB-1:0] szx, szy, ezx, ezy;
  logic signed [NW+1:0] pt [0:3];
  logic signed [CB-1:0] cc [0:3];
  logic sg [0:3];
  logic signed [NW+1:0] vq [0:3];

  for (genvar k = 0; k < 4; k++) begin : g_place
    assign cc[k] = qside[k][QW][CB:1];
    assign sg[k] = qside[k][QW][0];
    always_comb begin
      // trunc(num/den + c): floor for negative num, then toward zero
      logic signed [NW+1:0] q;
      logic nz;
      nz = (qrem[k][QW] != '0);
      q  = sg[k] ? -(NW+2)'(qnum[k][QW]) - (NW+2)'(nz) : (NW+2)'(qnum[k][QW]);
      vq[k] = q + (NW+2)'(cc[k]);
      pt[k] = (nz && vq[k][NW+1]) ? vq[k] + (NW+2)'(1) : vq[k];
    end
  end

  assign {passz, szx, szy, ezx, ezy} = qside[0][QW][DSW-1:CB+1];

  function automatic logic [NW+1:0] abs_d(input logic signed [NW+1:0] v);
    abs_d = v[NW+1] ? (NW+2)'(0) - v : v;
  endfunction

  logic vc;
  logic passc;
  logic signed [CB-1:0] ecx, ecy;
  logic signed [NW+1:0] x1c, y1c, x2c, y2c;
  logic [NW+1:0] ax1c, ax2c, ay1c, ay2c;

  always_ff @(posedge clk) begin
    if (rst) begin
      vc <= 1'b0;
    end else if (adv) begin
      vc <= qv[0][QW];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      passc <= passz; ecx <= ezx; ecy <= ezy;
      x1c <= pt[0]; y1c <= pt[1]; x2c <= pt[2]; y2c <= pt[3];
      ax1c <= abs_d(pt[0] - (NW+2)'(szx));
      ax2c <= abs_d(pt[2] - (NW+2)'(szx));
      ay1c <= abs_d(pt[1] - (NW+2)'(szy));
      ay2c <= abs_d(pt[3] - (NW+2)'(szy));
    end
  end

  logic first;
  always_comb first = (ax1c != ax2c) ? (ax1c < ax2c) : (ay1c < ay2c);

  // output register
  assign adv = !out_valid || !out_stall;
  assign in_stall = rst || !adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= vc;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (passc) begin
        new_end_x <= OUT_BITS'(ecx);
        new_end_y <= OUT_BITS'(ecy);
        valid_res <= 1'b0;
      end else begin
        new_end_x <= first ? OUT_BITS'(x1c) : OUT_BITS'(x2c);
        new_end_y <= first ? OUT_BITS'(y1c) : OUT_BITS'(y2c);
        valid_res <= 1'b1;
      end
    end
  end

endmodule

### verif/tb.sv
// testbench for the line/circle beam clip: scoreboard, stimulus and checks
`timescale 1ns / 1ps

module tb;
  import lci_pkg::*;

  localparam int CB = COORD_BITS_DEF;
  localparam int RFB = ROOT_FRAC_BITS_DEF;
  // 5 + 37 + 2 + 63 + 2 stages, plus margin
  localparam int PIPE_DEPTH = 150;

  typedef struct {
    logic signed [OUT_BITS-1:0] x;
    logic signed [OUT_BITS-1:0] y;
    logic                       ok;
  } clip_t;

  // integer root with RFB fractional bits, digit by digit
  function automatic longint unsigned fixed_sqrt(longint unsigned d);
    logic [127:0] val, rem, root, trial;
    val = {64'd0, d} << (2 * RFB);
    rem = 0;
    root = 0;
    for (int i = 63; i >= 0; i--) begin
      rem = (rem << 2) | ((val >> (2 * i)) & 128'd3);
      root = root << 1;
      trial = (root << 1) | 128'd1;
      if (rem >= trial) begin
        rem = rem - trial;
        root = root | 128'd1;
      end
    end
    return root[63:0];
  endfunction

  // num/den + c truncated toward zero as a whole, den > 0
  function automatic longint trunc_place(longint num, longint den, longint c);
    longint q, r, v;
    q = num / den;
    r = num % den;
    if (r != 0 && num < 0) q = q - 1;
    v = q + c;
    if (r == 0) return v;
    return (v >= 0) ? v : v + 1;
  endfunction

  function automatic longint mag(longint v);
    return v < 0 ? -v : v;
  endfunction

  class clip_scoreboard;
    clip_t pending[$];
    int    errors;
    logic [HALF_WIDTH_BITS-1:0] half_width;

    function new();
      errors = 0;
      half_width = HALF_WIDTH_RESET;
    endfunction

    function void note_query(longint sx, longint sy, longint ex, longint ey,
                             longint cx, longint cy, longint rad);
      clip_t  e;
      longint r, dx, dy, dr, det, d2, rr, root, den, sg, bx, by, tx, ty;
      longint x1, y1, x2, y2;
      bit     first;
      r = rad + half_width;
      dx = ex - sx;
      dy = ey - sy;
      dr = dx * dx + dy * dy;
      det = (sx - cx) * (ey - cy) - (sy - cy) * (ex - cx);
      d2 = det * det;
      rr = r * r * dr;
      if (dr == 0 || d2 > rr) begin
        e.x = OUT_BITS'(ex);
        e.y = OUT_BITS'(ey);
        e.ok = 1'b0;
      end else begin
        root = longint'(fixed_sqrt(longint'(rr - d2)));
        den = dr * (64'sd1 <<< RFB);
        sg = dy < 0 ? -64'sd1 : 64'sd1;
        bx = det * dy * (64'sd1 <<< RFB);
        by = -det * dx * (64'sd1 <<< RFB);
        tx = sg * dx * root;
        ty = mag(dy) * root;
        x1 = trunc_place(bx + tx, den, cx);
        y1 = trunc_place(by + ty, den, cy);
        x2 = trunc_place(bx - tx, den, cx);
        y2 = trunc_place(by - ty, den, cy);
        if (mag(x1 - sx) != mag(x2 - sx)) first = mag(x1 - sx) < mag(x2 - sx);
        else first = mag(y1 - sy) < mag(y2 - sy);
        e.x = first ? OUT_BITS'(x1) : OUT_BITS'(x2);
        e.y = first ? OUT_BITS'(y1) : OUT_BITS'(y2);
        e.ok = 1'b1;
      end
      pending.push_back(e);
    endfunction

    function void check_clip(logic signed [OUT_BITS-1:0] x,
                             logic signed [OUT_BITS-1:0] y, logic ok);
      clip_t e;
      if (pending.size() == 0) begin
        $error("unexpected item x=%0d y=%0d valid_res=%0b", x, y, ok);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (x !== e.x) begin
        $error("new_end_x expected %0d actual %0d", e.x, x);
        errors++;
      end
      if (y !== e.y) begin
        $error("new_end_y expected %0d actual %0d", e.y, y);
        errors++;
      end
      if (ok !== e.ok) begin
        $error("valid_res expected %0b actual %0b", e.ok, ok);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0, out_stall = 0, cfg_valid = 0;
  logic in_stall, out_valid, cfg_ready, valid_res;
  logic signed [CB-1:0] start_x = 0, start_y = 0, end_x = 0, end_y = 0;
  logic signed [CB-1:0] center_x = 0, center_y = 0;
  logic [RADIUS_BITS-1:0] obstacle_radius = 0;
  logic signed [OUT_BITS-1:0] new_end_x, new_end_y;
  logic [HALF_WIDTH_BITS-1:0] cfg_data = 0;

  bit idle_on = 1;
  bit sending_done = 0;
  clip_scoreboard sb;

  always #10 clk = ~clk;

  line_circle_intersection_clip dut (
    .clk, .rst, .in_valid, .in_stall, .start_x, .start_y, .end_x, .end_y,
    .center_x, .center_y, .obstacle_radius, .out_valid, .out_stall,
    .new_end_x, .new_end_y, .valid_res, .cfg_valid, .cfg_ready, .cfg_data
  );

  // output side: random stall, check on accept
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) sb.check_clip(new_end_x, new_end_y, valid_res);
      out_stall <= idle_on && ($urandom_range(99) < 33);
    end
  end

  // valid stays high from one accepted item to the next unless the side idles
  task automatic send_query(int sx, int sy, int ex, int ey, int cx, int cy, int rad);
    while (idle_on && $urandom_range(99) < 33) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    start_x <= CB'(sx); start_y <= CB'(sy); end_x <= CB'(ex); end_y <= CB'(ey);
    center_x <= CB'(cx); center_y <= CB'(cy);
    obstacle_radius <= RADIUS_BITS'(rad);
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_query(longint'(sx), longint'(sy), longint'(ex), longint'(ey),
                  longint'(cx), longint'(cy), longint'(rad));
  endtask

  task automatic write_half_width(int hw);
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (PIPE_DEPTH) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= HALF_WIDTH_BITS'(hw);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    sb.half_width = HALF_WIDTH_BITS'(hw);
  endtask

  function automatic int rnd_coord();
    return $signed($urandom_range(0, 32767) - 16384);
  endfunction

  // random query: mostly a segment starting near the circle within a random offset span, else fully random
  task automatic random_query(int span);
    int cx, cy, sx, sy;
    cx = rnd_coord();
    cy = rnd_coord();
    if ($urandom_range(9) < 2) begin
      send_query(rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord(), cx, cy,
                 $urandom_range(1023));
    end else begin
      sx = cx + $signed($urandom_range(0, 2 * span)) - span;
      sy = cy + $signed($urandom_range(0, 2 * span)) - span;
      if (sx > 16383) sx = 16383;
      if (sx < -16384) sx = -16384;
      if (sy > 16383) sy = 16383;
      if (sy < -16384) sy = -16384;
      send_query(sx, sy, rnd_coord(), rnd_coord(), cx, cy, $urandom_range(1023));
    end
  endtask

  initial begin
    int hw_list[4] = '{0, 255, 77, 3};
    sb = new();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // directed: extremes, horizontal and vertical lines, tangent, miss, degenerate
    send_query(0, 0, 0, 0, 0, 0, 10);
    send_query(-16384, -16384, 16383, 16383, 0, 0, 1023);
    send_query(16383, 16383, -16384, -16384, 0, 0, 0);
    send_query(-16384, 0, 16383, 0, 0, 0, 100);
    send_query(0, 16383, 0, -16384, 0, 0, 100);
    send_query(-100, 13, 100, 13, 0, 0, 10);
    send_query(-100, 50, 100, 50, 0, 0, 10);
    send_query(16383, -16384, -16384, 16383, 16383, 16383, 1023);
    send_query(-16384, 16383, 16383, -16384, -16384, -16384, 1023);
    send_query(5, 5, 5, 5, 5, 5, 0);
    send_query(-1, -1, 1, 1, 0, 0, 0);
    send_query(0, 0, 1, 0, 0, 0, 0);
    send_query(100, 100, 50, 200, 80, 120, 512);
    send_query(-16384, -16384, -16383, -16384, -16384, -16384, 1023);
    foreach (hw_list[p]) begin
      write_half_width(hw_list[p]);
      for (int i = 0; i < 400; i++) begin
        if (i == 150) idle_on = 0;
        if (i == 250) idle_on = 1;
        random_query($urandom_range(1) ? 1500 : 16383);
      end
    end
    in_valid <= 1'b0;
    sending_done = 1;
  end

  initial begin
    wait (sending_done);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (PIPE_DEPTH) @(posedge clk);
    if (sb.errors == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

  initial begin
    #20ms;
    $display("Some tests failed");
    $finish;
  end

endmodule

### sim.f
rtl/lci_pkg.sv
rtl/lci_sqrt_cell.sv
rtl/lci_div_cell.sv
rtl/line_circle_intersection_clip.sv
verif/tb.sv
